### src/cfaf_pkg.sv
`default_nettype none
package cfaf_pkg;

  localparam int DEF_ADDRESS_COUNT = 64;
  localparam int DEF_MAX_RULES     = 8;
  localparam int DEF_PAYLOAD_BYTES = 8;
  localparam int WORDS_PER_RULE    = 8;

  localparam logic [7:0] CFG_ADDRESS_ENABLE = 8'd0;
  localparam logic [7:0] CFG_TYPE_ENABLE    = 8'd1;
  localparam logic [7:0] CFG_CODE_ENABLE    = 8'd2;
  localparam logic [7:0] CFG_ACTIVE_RULES   = 8'd3;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_RULE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [6:0]  slave_address;
    logic [1:0]  msg_type;
    logic [2:0]  f_code;
    logic [3:0]  payload_len;
    logic [63:0] payload;
    logic [2:0]  rule_index;
    logic        rule_part;
    logic [1:0]  word_select;
    logic [63:0] rule_word;
  } in_item_t;

  typedef struct packed {
    logic accept;
    logic malformed;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### src/can_frame_acceptance_filter.sv
// Latency: a frame whose content needs no rule lookup gives its result strobe in the
// cycle after start; otherwise it steps through RUN, one lookup per pair and rule (at most
// 6 pairs), then DRAIN and DONE. A new frame is taken only once the block is idle again;
// each lookup reads two rule words. A rule word write is taken only while idle and does not
// make the block busy. Synchronous reset restores the configuration registers; rule words are
// undefined until written. The result is shown for one cycle and the receiver cannot stall.
`default_nettype none
module can_frame_acceptance_filter #(
  parameter int ADDRESS_COUNT = cfaf_pkg::DEF_ADDRESS_COUNT,
  parameter int MAX_RULES     = cfaf_pkg::DEF_MAX_RULES,
  parameter int PAYLOAD_BYTES = cfaf_pkg::DEF_PAYLOAD_BYTES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire cfaf_pkg::in_item_t  item,
  output      logic                busy,
  output      logic                result_valid,
  output      cfaf_pkg::out_item_t result,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [7:0]          cfg_index,
  input  wire logic [63:0]         cfg_data
);
  import cfaf_pkg::*;

  localparam int DEPTH = MAX_RULES * WORDS_PER_RULE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RCW   = $clog2(MAX_RULES + 1);

  logic [63:0] address_enable;
  logic [3:0]  type_enable;
  logic [7:0]  code_enable;
  logic [3:0]  active_rules;

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_a, rd_b;

  state_t state, state_next;

  logic [63:0]    payload_q;
  logic           is_range_q;
  logic [7:0]     left_q;
  logic [3:0]     cnt_q;
  logic [RCW-1:0] nrules_q;
  logic [2:0]     pair_q;
  logic [RCW-1:0] rule_q;
  logic           issued_q;
  logic [5:0]     sel_a_q, sel_b_q;
  logic           hit_q, bad_q, base_ok_q, fixed_q, fixed_val_q;

  logic           accept_in;
  logic [3:0]     len_c;
  logic [4:0]     act5, lim5;
  logic [RCW-1:0] nrules;
  logic           from_master, dir_ok, parse;
  logic [7:0]     b0, b1, span, avail;
  logic [3:0]     cnt_calc;
  logic           bad_calc, base_ok;
  logic [7:0]     reg_v, data_v;
  logic [2:0]     ri, di;
  logic           last_issue;
  logic [AW-1:0]  ra, rb;

  assign cfg_ready = 1'b1;
  assign busy = (state != ST_IDLE);
  assign accept_in = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_enable <= '1;
      type_enable    <= 4'hF;
      code_enable    <= 8'hFF;
      active_rules   <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ADDRESS_ENABLE: address_enable <= cfg_data;
        CFG_TYPE_ENABLE:    type_enable    <= cfg_data[3:0];
        CFG_CODE_ENABLE:    code_enable    <= cfg_data[7:0];
        CFG_ACTIVE_RULES:   active_rules   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Decode of the incoming frame.
  always_comb begin
    len_c = (item.payload_len > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES) : item.payload_len;
    act5 = {1'b0, active_rules};
    lim5 = 5'(MAX_RULES);
    nrules = RCW'((act5 > lim5) ? lim5 : act5);
    from_master = !item.msg_type[0];
    dir_ok = item.f_code[1] ? !from_master : from_master;
    parse = (active_rules != 4'd0) && !item.f_code[2] && dir_ok;
    b0 = item.payload[7:0];
    b1 = item.payload[15:8];
    span = b1 - b0;
    avail = {4'd0, len_c} - 8'd2;
    if (!item.f_code[0]) begin
      if (len_c < 4'd2) begin
        cnt_calc = 4'd0;
        bad_calc = 1'b1;
      end else if (b0 > b1) begin
        cnt_calc = 4'd0;
        bad_calc = 1'b0;
      end else if (span >= avail) begin
        cnt_calc = avail[3:0];
        bad_calc = 1'b1;
      end else begin
        cnt_calc = 4'(span + 8'd1);
        bad_calc = 1'b0;
      end
    end else begin
      cnt_calc = len_c >> 1;
      bad_calc = len_c[0];
    end
    base_ok = (32'(item.slave_address) < 32'(ADDRESS_COUNT))
              && address_enable[item.slave_address[5:0]]
              && type_enable[item.msg_type] && code_enable[item.f_code];
  end

  // Register and data value of the current pair.
  always_comb begin
    ri = {pair_q[1:0], 1'b0};
    di = is_range_q ? 3'(pair_q + 3'd2) : {pair_q[1:0], 1'b1};
    reg_v  = is_range_q ? left_q + {5'd0, pair_q} : payload_q[8*ri +: 8];
    data_v = payload_q[8*di +: 8];
    ra = AW'({rule_q, 1'b0, reg_v[7:6]});
    rb = AW'({rule_q, 1'b1, data_v[7:6]});
    last_issue = (pair_q == 3'(cnt_q - 4'd1)) && (rule_q == nrules_q - RCW'(1));
  end

  always_ff @(posedge clk) begin
    if (accept_in && item.kind == KIND_RULE && 32'(item.rule_index) < 32'(MAX_RULES)) begin
      mem[AW'({item.rule_index, item.rule_part, item.word_select})] <= item.rule_word;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    result_valid = 1'b0;
    result.accept = base_ok_q && (fixed_q ? fixed_val_q : hit_q);
    result.malformed = bad_q;
    unique case (state)
      ST_IDLE: begin
        if (accept_in && item.kind == KIND_FRAME) begin
          state_next = (parse && cnt_calc != 4'd0) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        result_valid = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    issued_q <= (state == ST_RUN);
    sel_a_q  <= reg_v[5:0];
    sel_b_q  <= data_v[5:0];
    if (state == ST_IDLE && accept_in && item.kind == KIND_FRAME) begin
      payload_q   <= item.payload;
      is_range_q  <= !item.f_code[0];
      left_q      <= b0;
      cnt_q       <= cnt_calc;
      nrules_q    <= nrules;
      pair_q      <= 3'd0;
      rule_q      <= '0;
      hit_q       <= 1'b0;
      base_ok_q   <= base_ok;
      fixed_q     <= !parse;
      fixed_val_q <= (active_rules == 4'd0) || item.f_code[2];
      bad_q       <= parse && bad_calc;
    end else begin
      if (state == ST_RUN) begin
        if (rule_q == nrules_q - RCW'(1)) begin
          rule_q <= '0;
          pair_q <= pair_q + 3'd1;
        end else begin
          rule_q <= rule_q + RCW'(1);
        end
      end
      if (issued_q && rd_a[sel_a_q] && rd_b[sel_b_q]) begin
        hit_q <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### src/cfaf_checker.sv
`default_nettype none
module cfaf_assertions (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire cfaf_pkg::in_item_t  item,
  input wire logic                busy,
  input wire logic                result_valid,
  input wire cfaf_pkg::out_item_t result
);
  import cfaf_pkg::*;

  // A result beat is only shown while a frame is in flight.
  assert property (@(posedge clk) disable iff (rst) result_valid |-> busy)
    else $error("result without a frame in flight");

  // The block frees itself right after the result beat.
  assert property (@(posedge clk) disable iff (rst) result_valid |=> !busy)
    else $error("busy after result");

  // A rule word write never occupies the block.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.kind == KIND_RULE) |=> (!busy && !result_valid))
    else $error("rule write occupied the block");

  // A frame always makes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.kind == KIND_FRAME) |=> busy)
    else $error("frame not taken");

endmodule

bind can_frame_acceptance_filter cfaf_assertions u_cfaf_assertions (
  .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
  .result_valid(result_valid), .result(result)
);
`default_nettype wire
